// ===== design/ttts_pkg.sv =====
`timescale 1ns / 1ps

package ttts_pkg;

  // One trit, 2 bits. Inputs may carry 10, which decodes to null.
  typedef logic [1:0] trit_t;

  localparam trit_t T_ZERO = 2'b00;
  localparam trit_t T_ONE  = 2'b01;
  localparam trit_t T_NULL = 2'b11;

  // Gate modes are trits too: 0 AND, 1 OR, null consensus.
  localparam trit_t MODE_AND  = T_ZERO;
  localparam trit_t MODE_OR   = T_ONE;

  localparam int TRITS_PER_DIM = 3;
  localparam int DIMS_PER_VEC  = 3;
  localparam int VEC_W         = 2 * TRITS_PER_DIM * DIMS_PER_VEC;
  localparam int NULLS_W       = 4;
  localparam int PERM_W        = 3;

  // First entry of the row order table (012).
  localparam logic [PERM_W-1:0] PERM_FIRST = 3'd0;

  typedef trit_t [TRITS_PER_DIM-1:0] row_t;  // indexed by column
  typedef row_t  [2:0]               blk_t;  // rows: result, mode, outcome

  function automatic trit_t decode(input logic [1:0] c);
    trit_t t;
    case (c)
      2'b00:   t = T_ZERO;
      2'b01:   t = T_ONE;
      default: t = T_NULL;
    endcase
    return t;
  endfunction

  function automatic trit_t g_and(input trit_t a, input trit_t b);
    trit_t t;
    if (a == T_ZERO || b == T_ZERO) t = T_ZERO;
    else if (a == T_ONE && b == T_ONE) t = T_ONE;
    else t = T_NULL;
    return t;
  endfunction

  function automatic trit_t g_or(input trit_t a, input trit_t b);
    trit_t t;
    if (a == T_ONE || b == T_ONE) t = T_ONE;
    else if (a == T_ZERO && b == T_ZERO) t = T_ZERO;
    else t = T_NULL;
    return t;
  endfunction

  function automatic trit_t g_cons(input trit_t a, input trit_t b);
    return (a != T_NULL && a == b) ? a : T_NULL;
  endfunction

  function automatic trit_t g_infer(input trit_t a, input trit_t b, input trit_t m);
    trit_t t;
    case (m)
      MODE_AND: t = g_and(a, b);
      MODE_OR:  t = g_or(a, b);
      default:  t = g_cons(a, b);
    endcase
    return t;
  endfunction

  function automatic trit_t g_learn(input trit_t a, input trit_t b, input trit_t r);
    trit_t t;
    if (g_and(a, b) == r) t = MODE_AND;
    else if (g_or(a, b) == r) t = MODE_OR;
    else t = T_NULL;
    return t;
  endfunction

  function automatic trit_t maj3(input trit_t a, input trit_t b, input trit_t c);
    trit_t t;
    if (a == b || a == c) t = a;
    else if (b == c) t = b;
    else t = T_NULL;
    return t;
  endfunction

  // Fill the lowest column that holds one lone null with agreeing partners.
  function automatic blk_t refine(input blk_t b);
    blk_t       r;
    logic       done;
    logic [1:0] n;
    trit_t      v;
    r    = b;
    done = 1'b0;
    for (int i = 0; i < TRITS_PER_DIM; i++) begin
      n = {1'b0, b[0][i] == T_NULL} + {1'b0, b[1][i] == T_NULL}
        + {1'b0, b[2][i] == T_NULL};
      v = maj3(b[0][i], b[1][i], b[2][i]);
      if (!done && n == 2'd1 && v != T_NULL) begin
        r[0][i] = v;
        r[1][i] = v;
        r[2][i] = v;
        done    = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic logic [NULLS_W-1:0] count_nul(input blk_t b);
    logic [NULLS_W-1:0] n;
    n = '0;
    for (int r = 0; r < 3; r++) begin
      for (int i = 0; i < TRITS_PER_DIM; i++) begin
        n = n + {{(NULLS_W-1){1'b0}}, b[r][i] == T_NULL};
      end
    end
    return n;
  endfunction

endpackage

// ===== design/ttts_vector_pipe.sv =====
`timescale 1ns / 1ps

// Three-stage datapath for one vector (three dimensions of three trits).
module ttts_vector_pipe (
  input  logic                          clk,
  input  logic                          en,
  input  logic [ttts_pkg::VEC_W-1:0]    a_vec,
  input  logic [ttts_pkg::VEC_W-1:0]    b_vec,
  input  logic [ttts_pkg::VEC_W-1:0]    c_vec,
  output logic [ttts_pkg::VEC_W-1:0]    em_vec,
  output logic [ttts_pkg::NULLS_W-1:0]  nulls
);
  import ttts_pkg::*;

  // Stage 1: decoded sources, learned modes, first outcomes.
  blk_t s1_a;           // [dimension][column]
  blk_t s1_b;
  blk_t s1_blk [3];     // per dimension: target, mode, outcome
  blk_t s1_a_next;
  blk_t s1_b_next;
  blk_t s1_blk_next [3];

  // Stage 2: re-inferred blocks, null count of tensor A's vector.
  blk_t               s2_blk [3];
  logic [NULLS_W-1:0] s2_nulls;
  blk_t               s2_blk_next [3];
  logic [NULLS_W-1:0] s2_nulls_next;

  logic [VEC_W-1:0] em_next;

  always_comb begin
    trit_t ta;
    trit_t tb;
    trit_t tc;
    for (int d = 0; d < DIMS_PER_VEC; d++) begin
      for (int k = 0; k < TRITS_PER_DIM; k++) begin
        ta = decode(a_vec[2*(3*d+k) +: 2]);
        tb = decode(b_vec[2*(3*d+k) +: 2]);
        tc = decode(c_vec[2*(3*d+k) +: 2]);
        s1_a_next[d][k]      = ta;
        s1_b_next[d][k]      = tb;
        s1_blk_next[d][0][k] = tc;
        s1_blk_next[d][1][k] = g_learn(ta, tb, tc);
        s1_blk_next[d][2][k] = maj3(ta, tb, tc);
      end
    end
  end

  always_comb begin
    blk_t  rb;
    trit_t r;
    for (int d = 0; d < DIMS_PER_VEC; d++) begin
      rb = refine(s1_blk[d]);
      for (int k = 0; k < TRITS_PER_DIM; k++) begin
        r = g_infer(s1_a[d][k], s1_b[d][k], rb[1][k]);
        s2_blk_next[d][0][k] = r;
        s2_blk_next[d][1][k] = rb[1][k];
        s2_blk_next[d][2][k] = maj3(s1_a[d][k], s1_b[d][k], r);
      end
    end
    // Rows of A in any order refine the same column contents, so one count serves.
    s2_nulls_next = count_nul(refine(s1_a));
  end

  always_comb begin
    blk_t  rb [3];
    trit_t t;
    for (int d = 0; d < DIMS_PER_VEC; d++) begin
      rb[d] = refine(s2_blk[d]);
    end
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < TRITS_PER_DIM; k++) begin
        t = maj3(rb[0][r][k], rb[1][r][k], rb[2][r][k]);
        em_next[2*(3*r+k) +: 2] = t;
      end
    end
  end

  // Advance all stages together; hold on stall.
  always_ff @(posedge clk) begin
    if (en) begin
      s1_a     <= s1_a_next;
      s1_b     <= s1_b_next;
      s1_blk   <= s1_blk_next;
      s2_blk   <= s2_blk_next;
      s2_nulls <= s2_nulls_next;
      em_vec   <= em_next;
      nulls    <= s2_nulls;
    end
  end

endmodule

// ===== design/ternary_tensor_transcend_step_top.sv =====
`timescale 1ns / 1ps

// An input transfer passes through the three register stages (stage 1, stage 2,
// output register) in turn before its output transfer.
// Throughput: one tensor triple per cycle; the three register stages advance
// together and hold in place only while a result waits with m_tready low.
// Reset (rst, synchronous, active high) clears the stage valid bits only;
// payload registers carry no reset.
module ternary_tensor_transcend_step_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // s_tdata from bit 0: tensor_a[53:0], tensor_b[107:54], tensor_c[161:108],
  // zero pad [167:162]
  input  logic [167:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // m_tdata from bit 0: emergent_tensor[53:0], role_perm_0[56:54],
  // role_perm_1[59:57], role_perm_2[62:60], role_nulls_0[66:63],
  // role_nulls_1[70:67], role_nulls_2[74:71], zero pad [79:75]
  output logic [79:0]  m_tdata
);
  import ttts_pkg::*;

  localparam int TENSOR_W = 3 * VEC_W;

  logic v1;
  logic v2;
  logic v3;
  logic en;

  logic [TENSOR_W-1:0] tensor_a;
  logic [TENSOR_W-1:0] tensor_b;
  logic [TENSOR_W-1:0] tensor_c;
  logic [TENSOR_W-1:0] emergent;
  logic [NULLS_W-1:0]  lane_nulls [3];

  // The whole pipe moves whenever the output slot is empty or being drained,
  // so a new transfer is taken in the same cycle a result leaves.
  assign en       = !v3 || m_tready;
  assign s_tready = en;
  assign m_tvalid = v3;

  assign tensor_a = s_tdata[TENSOR_W-1:0];
  assign tensor_b = s_tdata[2*TENSOR_W-1:TENSOR_W];
  assign tensor_c = s_tdata[3*TENSOR_W-1:2*TENSOR_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // One lane per vector: learn, refine, re-infer, refine, merge dimensions.
  for (genvar v = 0; v < 3; v++) begin : g_lane
    ttts_vector_pipe u_lane (
      .clk    (clk),
      .en     (en),
      .a_vec  (tensor_a[v*VEC_W +: VEC_W]),
      .b_vec  (tensor_b[v*VEC_W +: VEC_W]),
      .c_vec  (tensor_c[v*VEC_W +: VEC_W]),
      .em_vec (emergent[v*VEC_W +: VEC_W]),
      .nulls  (lane_nulls[v])
    );
  end

  // Permuting rows never changes which column refines or the null count, so
  // every order ties and the first one is always the pick.
  assign m_tdata = {5'b0,
                    lane_nulls[2], lane_nulls[1], lane_nulls[0],
                    PERM_FIRST, PERM_FIRST, PERM_FIRST,
                    emergent};

  // Null counts of a 3x3 block never exceed nine.
  a_nulls_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[66:63] <= 4'd9 && m_tdata[70:67] <= 4'd9
                  && m_tdata[74:71] <= 4'd9))
    else $error("role null count out of range");

  // A stalled middle stage keeps its item.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (!s_tready && v2) |=> v2)
    else $error("stage 2 item lost during stall");

  // Output slot empties only through a transfer.
  a_out_drain: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid)
    else $error("result dropped without transfer");

endmodule

// ===== bench/ternary_tensor_transcend_step_top_tb.sv =====
`timescale 1ns / 1ps

module ternary_tensor_transcend_step_top_tb;
  import ttts_pkg::*;

  localparam int HOLD_LEN   = 300;   // long output hold for the pressure test
  localparam int IDLE_LIMIT = 2000;  // cycles with no transfer before giving up
  localparam int DRAIN_WAIT = 8;     // pipeline is 3 deep; leave some margin

  localparam logic [53:0] ALL_ZERO = '0;
  localparam logic [53:0] ALL_ONE  = {27{T_ONE}};
  localparam logic [53:0] ALL_NULL = {27{T_NULL}};
  localparam logic [53:0] ALL_ODD  = {27{2'b10}};  // alternate null code

  // Mirrors m_tdata: lowest field last.
  typedef struct packed {
    logic [4:0]                  pad;
    logic [2:0][NULLS_W-1:0]     nulls;
    logic [2:0][PERM_W-1:0]      perm;
    logic [53:0]                 emergent;
  } transcend_t;

  typedef trit_t [2:0][2:0] grid_t;  // [row][column]

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [167:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [79:0]  m_tdata;

  transcend_t pending_results [$];
  int         items_sent = 0;
  int         results_checked = 0;
  int         error_count = 0;
  int         idle_cycles = 0;
  int         idle_pct = 0;       // sender gap chance, percent
  int         stall_pct = 0;      // receiver stall chance, percent
  int         hold_requests = 0;  // bump to start one long output hold

  ternary_tensor_transcend_step_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Trit arithmetic for the predictor
  // ---------------------------------------------------------------------
  function automatic trit_t trit_of(input logic [1:0] code);
    if (code == 2'b00) return T_ZERO;
    if (code == 2'b01) return T_ONE;
    return T_NULL;
  endfunction

  function automatic trit_t trit_at(input logic [53:0] w, input int n);
    return trit_of(w[2*n +: 2]);
  endfunction

  function automatic trit_t gate_and(input trit_t a, input trit_t b);
    if (a == T_ZERO || b == T_ZERO) return T_ZERO;
    return (a == T_ONE && b == T_ONE) ? T_ONE : T_NULL;
  endfunction

  function automatic trit_t gate_or(input trit_t a, input trit_t b);
    if (a == T_ONE || b == T_ONE) return T_ONE;
    return (a == T_ZERO && b == T_ZERO) ? T_ZERO : T_NULL;
  endfunction

  function automatic trit_t gate_apply(input trit_t a, input trit_t b, input trit_t mode);
    if (mode == MODE_AND) return gate_and(a, b);
    if (mode == MODE_OR) return gate_or(a, b);
    return (a != T_NULL && a == b) ? a : T_NULL;  // consensus
  endfunction

  function automatic trit_t gate_learn(input trit_t a, input trit_t b, input trit_t goal);
    if (gate_and(a, b) == goal) return MODE_AND;
    if (gate_or(a, b) == goal) return MODE_OR;
    return T_NULL;
  endfunction

  function automatic trit_t vote3(input trit_t a, input trit_t b, input trit_t c);
    if (a == b || a == c) return a;
    if (b == c) return b;
    return T_NULL;
  endfunction

  // Fill the first column whose single null sits beside two agreeing trits.
  function automatic grid_t fill_lone_null(input grid_t g);
    grid_t f;
    int    nulls;
    trit_t v;
    f = g;
    for (int col = 0; col < 3; col++) begin
      nulls = 0;
      for (int row = 0; row < 3; row++) if (g[row][col] == T_NULL) nulls++;
      v = vote3(g[0][col], g[1][col], g[2][col]);
      if (nulls == 1 && v != T_NULL) begin
        for (int row = 0; row < 3; row++) f[row][col] = v;
        return f;
      end
    end
    return f;
  endfunction

  function automatic int nulls_in(input grid_t g);
    int n;
    n = 0;
    for (int row = 0; row < 3; row++)
      for (int col = 0; col < 3; col++)
        if (g[row][col] == T_NULL) n++;
    return n;
  endfunction

  // Source dimension placed in row r by role permutation p.
  function automatic int role_row(input int p, input int r);
    logic [5:0] rows;  // row 0 in the low bits
    case (p)
      1:       rows = {2'd1, 2'd2, 2'd0};
      2:       rows = {2'd2, 2'd0, 2'd1};
      3:       rows = {2'd0, 2'd2, 2'd1};
      4:       rows = {2'd1, 2'd0, 2'd2};
      5:       rows = {2'd0, 2'd1, 2'd2};
      default: rows = {2'd2, 2'd1, 2'd0};
    endcase
    return int'(rows[2*r +: 2]);
  endfunction

  function automatic transcend_t predict_transcend(input logic [161:0] pkt);
    logic [53:0]      ta, tb, tc;
    trit_t [2:0]      a, b, c;
    grid_t            blk, dims;
    grid_t [2:0]      merged;
    int               n, best_p, best_n;
    transcend_t       res;
    ta  = pkt[53:0];
    tb  = pkt[107:54];
    tc  = pkt[161:108];
    res = '0;
    for (int v = 0; v < 3; v++) begin
      for (int d = 0; d < 3; d++) begin
        for (int k = 0; k < 3; k++) begin
          n    = 9*v + 3*d + k;
          a[k] = trit_at(ta, n);
          b[k] = trit_at(tb, n);
          c[k] = trit_at(tc, n);
          blk[0][k] = c[k];
          blk[1][k] = gate_learn(a[k], b[k], c[k]);
          blk[2][k] = vote3(a[k], b[k], c[k]);
        end
        blk = fill_lone_null(blk);
        // re-infer with the refined modes
        for (int k = 0; k < 3; k++) begin
          blk[0][k] = gate_apply(a[k], b[k], blk[1][k]);
          blk[2][k] = vote3(a[k], b[k], blk[0][k]);
        end
        merged[d] = fill_lone_null(blk);
      end
      for (int r = 0; r < 3; r++)
        for (int k = 0; k < 3; k++)
          res.emergent[2*(9*v + 3*r + k) +: 2] =
            vote3(merged[0][r][k], merged[1][r][k], merged[2][r][k]);

      for (int d = 0; d < 3; d++)
        for (int k = 0; k < 3; k++)
          dims[d][k] = trit_at(ta, 9*v + 3*d + k);
      best_p = 0;
      best_n = 1000;
      for (int p = 0; p < 6; p++) begin
        for (int r = 0; r < 3; r++)
          for (int k = 0; k < 3; k++)
            blk[r][k] = dims[role_row(p, r)][k];
        n = nulls_in(fill_lone_null(blk));
        if (n < best_n) begin
          best_n = n;
          best_p = p;
        end
      end
      res.perm[v]  = best_p[PERM_W-1:0];
      res.nulls[v] = best_n[NULLS_W-1:0];
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Result checking and watchdog, all on the rising edge
  // ---------------------------------------------------------------------
  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    transcend_t want, got;
    if (rst) begin
      idle_cycles = 0;
    end else begin
      // check the output transfer before queuing the input of the same edge
      if (m_tvalid && m_tready) begin
        got = transcend_t'(m_tdata);
        if (pending_results.size() == 0) begin
          $display("%0t: result with nothing expected, actual %0h", $time, m_tdata);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("emergent_tensor", 64'(want.emergent), 64'(got.emergent));
          for (int v = 0; v < 3; v++) begin
            check_field($sformatf("role_perm_%0d", v), 64'(want.perm[v]), 64'(got.perm[v]));
            check_field($sformatf("role_nulls_%0d", v), 64'(want.nulls[v]),
                        64'(got.nulls[v]));
          end
          results_checked++;
        end
      end
      if (s_tvalid && s_tready) pending_results.push_back(predict_transcend(s_tdata[161:0]));

      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Receiver: random stalls, plus a long hold on request
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    int hold_seen;
    int hold_left;
    if (hold_seen != hold_requests) begin
      hold_seen = hold_requests;
      hold_left = HOLD_LEN;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // ---------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------
  // Enter and leave at a falling edge; hold the item until its transfer.
  task automatic send_tensors(input logic [53:0] a, input logic [53:0] b,
                              input logic [53:0] c);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, c, b, a};
    do @(posedge clk); while (!s_tready);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic rest_sender();
    s_tvalid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [1:0] rand_code(input int null_pct);
    if ($urandom_range(99) < null_pct) return $urandom_range(1) ? T_NULL : 2'b10;
    return {1'b0, 1'($urandom_range(1))};
  endfunction

  // Mix of raw noise, gate-derived targets and sparsely null tensors.
  task automatic make_tensors(output logic [53:0] a, output logic [53:0] b,
                              output logic [53:0] c);
    int    kind;
    trit_t ra, rb, goal, mode;
    kind = $urandom_range(99);
    a = '0;
    b = '0;
    c = '0;
    if (kind < 20) begin
      a = 54'({$urandom, $urandom});
      b = 54'({$urandom, $urandom});
      c = 54'({$urandom, $urandom});
    end else if (kind < 70) begin
      // target follows a random gate per trit, so learning finds real modes
      for (int n = 0; n < 27; n++) begin
        a[2*n +: 2] = rand_code(15);
        b[2*n +: 2] = rand_code(15);
        ra = trit_of(a[2*n +: 2]);
        rb = trit_of(b[2*n +: 2]);
        case ($urandom_range(2))
          0:       mode = MODE_AND;
          1:       mode = MODE_OR;
          default: mode = T_NULL;
        endcase
        goal = gate_apply(ra, rb, mode);
        if ($urandom_range(9) == 0) c[2*n +: 2] = rand_code(50);
        else if (goal == T_NULL) c[2*n +: 2] = rand_code(100);
        else c[2*n +: 2] = goal;
      end
    end else begin
      for (int n = 0; n < 27; n++) begin
        a[2*n +: 2] = rand_code(12);
        b[2*n +: 2] = rand_code(12);
        c[2*n +: 2] = rand_code(12);
      end
    end
  endtask

  task automatic run_random(input int count);
    logic [53:0] a, b, c;
    repeat (count) begin
      make_tensors(a, b, c);
      send_tensors(a, b, c);
    end
    rest_sender();
  endtask

  // Every (a, b, c) trit combination once, rotated by shift.
  task automatic send_all_combos(input int shift, input logic [1:0] null_code);
    logic [53:0]      a, b, c;
    logic [2:0][1:0]  codes;
    int               idx;
    codes = {null_code, T_ONE, T_ZERO};
    for (int n = 0; n < 27; n++) begin
      idx = (n + shift) % 27;
      a[2*n +: 2] = codes[idx % 3];
      b[2*n +: 2] = codes[(idx / 3) % 3];
      c[2*n +: 2] = codes[idx / 9];
    end
    send_tensors(a, b, c);
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------
  task automatic test_directed();
    idle_pct  = 0;
    stall_pct = 0;
    // field extremes and both null codes
    send_tensors(ALL_ZERO, ALL_ZERO, ALL_ZERO);
    send_tensors(ALL_ONE, ALL_ONE, ALL_ONE);
    send_tensors(ALL_NULL, ALL_NULL, ALL_NULL);
    send_tensors(ALL_ODD, ALL_ODD, ALL_ODD);
    send_tensors(ALL_NULL, ALL_ZERO, ALL_ONE);
    // AND mode, OR mode, and a target neither gate reaches (consensus)
    send_tensors(ALL_ONE, ALL_ZERO, ALL_ZERO);
    send_tensors(ALL_ONE, ALL_ZERO, ALL_ONE);
    send_tensors(ALL_ONE, ALL_ZERO, ALL_NULL);
    send_tensors(ALL_ONE, ALL_ONE, ALL_ODD);
    // lone nulls beside agreeing trits, in various columns
    send_tensors(ALL_ONE, ALL_ONE, ALL_ONE ^ 54'h3 << 8);
    send_tensors(ALL_ZERO, ALL_ZERO, ALL_ZERO | 54'h3 << 2 | 54'h3 << 22);
    send_tensors(ALL_ONE ^ 54'h2 << 0, ALL_ONE, ALL_ONE);
    // role search: tensor_a with nulls spread unevenly over its dimensions
    send_tensors(54'h3F | 54'h30 << 18 | 54'h3 << 48, ALL_ONE, ALL_ZERO);
    send_tensors({18'h3FFFF, 18'h15555, 18'h00C0C}, ALL_ZERO, ALL_ONE);
    // exhaustive trit combinations
    send_all_combos(0, T_NULL);
    send_all_combos(5, 2'b10);
    send_all_combos(13, T_NULL);
    send_all_combos(22, 2'b10);
    rest_sender();
  endtask

  task automatic test_free_flow();
    idle_pct  = 0;
    stall_pct = 0;
    run_random(400);
  endtask

  task automatic test_sender_gaps();
    idle_pct  = 72;
    stall_pct = 0;
    run_random(400);
  endtask

  task automatic test_receiver_stalls();
    idle_pct  = 0;
    stall_pct = 72;
    run_random(350);
  endtask

  task automatic test_both_idle();
    idle_pct  = 18;
    stall_pct = 18;
    run_random(350);
  endtask

  // Hold the output off while offering input every cycle; the pipe fills.
  task automatic test_output_hold();
    idle_pct  = 0;
    stall_pct = 0;
    hold_requests++;
    run_random(150);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed();
    test_free_flow();
    test_sender_gaps();
    test_receiver_stalls();
    test_both_idle();
    test_output_hold();

    // drain, then watch for stray results
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Covered %0d tensor triples and %0d checked results: gate and refine corners,",
             items_sent, results_checked);
    $display("noise and gate-derived tensors, under free flow, gaps, stalls and a long hold.");
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/ttts_pkg.sv
design/ttts_vector_pipe.sv
design/ternary_tensor_transcend_step_top.sv
bench/ternary_tensor_transcend_step_top_tb.sv
